// File: rtl/srmg_pkg.sv
// shared types and constants of the stepper ramp move generator
package srmg_pkg;

   // payload widths fixed by the transaction format
   localparam int MOVE_W     = 24;
   localparam int SLOPE_W    = 12;
   localparam int ICEPT_W    = 24;
   localparam int LIMIT_W    = 16;
   localparam int TIMEOUT_W  = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register index codes (byte address bits [4:2])
   localparam logic [2:0] REG_RAMP_SLOPE      = 3'd0;
   localparam logic [2:0] REG_RAMP_INTERCEPT  = 3'd1;
   localparam logic [2:0] REG_INTERVAL_MIN    = 3'd2;
   localparam logic [2:0] REG_INTERVAL_MAX    = 3'd3;
   localparam logic [2:0] REG_MOVE_TIMEOUT_US = 3'd4;

   // action codes
   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_TICK  = 1'b1;

   // register reset values
   localparam logic [SLOPE_W-1:0]   RAMP_SLOPE_RST      = 12'd400;
   localparam logic [ICEPT_W-1:0]   RAMP_INTERCEPT_RST  = 24'd1400000;
   localparam logic [LIMIT_W-1:0]   INTERVAL_MIN_RST    = 16'd600;
   localparam logic [LIMIT_W-1:0]   INTERVAL_MAX_RST    = 16'd1600;
   localparam logic [TIMEOUT_W-1:0] MOVE_TIMEOUT_US_RST = 32'd30000000;

   // floor(v / 50000) = (v * RECIP_50000) >> RECIP_SHIFT, exact for v < 2**24
   localparam int               RECIP_SHIFT = 40;
   localparam logic [24:0]      RECIP_50000 = 25'd21990233;
   localparam int               QUOT_W      = 9;
   localparam int               STEP50_W    = 15;

   // input transaction
   typedef struct packed {
      logic                     action;
      logic signed [MOVE_W-1:0] move_ticks;
   } req_type;

   // result transaction
   typedef struct packed {
      logic step_pulse;
      logic step_ccw;
      logic move_done;
      logic move_timed_out;
      logic busy_res;
   } rsp_type;

   // configuration register set
   typedef struct packed {
      logic [SLOPE_W-1:0]   ramp_slope;
      logic [ICEPT_W-1:0]   ramp_intercept;
      logic [LIMIT_W-1:0]   interval_min;
      logic [LIMIT_W-1:0]   interval_max;
      logic [TIMEOUT_W-1:0] move_timeout_us;
   } cfg_type;

endpackage

// File: rtl/srmg_interval.sv
// next step interval from the ramp product and the interval limits
module srmg_interval #(
   parameter int COUNT_WIDTH    = 24,
   parameter int INTERVAL_WIDTH = 16
) (
   input  logic [COUNT_WIDTH+srmg_pkg::SLOPE_W-1:0] ramp_prod,
   input  srmg_pkg::cfg_type                        cfg,
   output logic [INTERVAL_WIDTH-1:0]                interval
);

   localparam int PROD_W = COUNT_WIDTH + srmg_pkg::SLOPE_W;
   localparam int CMP_W  = (PROD_W > srmg_pkg::ICEPT_W) ? PROD_W : srmg_pkg::ICEPT_W;
   localparam int MUL_W  = srmg_pkg::ICEPT_W + 25;
   localparam logic [31:0] IVL_MAX = 32'((64'd1 << INTERVAL_WIDTH) - 64'd1);

   logic [CMP_W-1:0]                  icept_ext;
   logic [CMP_W-1:0]                  prod_ext;
   logic [CMP_W-1:0]                  diff;
   logic                              positive;
   logic [srmg_pkg::ICEPT_W-1:0]      v_pos;
   logic [MUL_W-1:0]                  recip_prod;
   logic [srmg_pkg::QUOT_W-1:0]       quot;
   logic [srmg_pkg::STEP50_W-1:0]     step50;
   logic [srmg_pkg::LIMIT_W-1:0]      lim_lo;
   logic [srmg_pkg::LIMIT_W-1:0]      lim_hi;
   logic [srmg_pkg::LIMIT_W-1:0]      lim_one;

   // intercept minus ramp product, negative results fold to zero
   assign icept_ext = CMP_W'(cfg.ramp_intercept);
   assign prod_ext  = CMP_W'(ramp_prod);
   assign positive  = prod_ext < icept_ext;
   assign diff      = icept_ext - prod_ext;
   assign v_pos     = positive ? diff[srmg_pkg::ICEPT_W-1:0] : '0;

   // divide by 1000 then floor to a multiple of 50, as one divide by 50000
   assign recip_prod = MUL_W'(v_pos) * MUL_W'(srmg_pkg::RECIP_50000);
   assign quot       = recip_prod[srmg_pkg::RECIP_SHIFT +: srmg_pkg::QUOT_W];
   assign step50     = {1'b0, quot, 5'b0} + {2'b0, quot, 4'b0} + {5'b0, quot, 1'b0};

   // raise to minimum, cut to maximum, never below one
   always_comb begin
      lim_lo  = (srmg_pkg::LIMIT_W'(step50) < cfg.interval_min)
              ? cfg.interval_min : srmg_pkg::LIMIT_W'(step50);
      lim_hi  = (lim_lo > cfg.interval_max) ? cfg.interval_max : lim_lo;
      lim_one = (lim_hi == '0) ? srmg_pkg::LIMIT_W'(1) : lim_hi;
      if (32'(lim_one) > IVL_MAX) begin
         interval = '1;
      end else begin
         interval = INTERVAL_WIDTH'(lim_one);
      end
   end

endmodule

// File: rtl/stepper_ramp_move_generator.sv
// top level of the stepper ramp move generator: handshake, registers, move state
// One transaction can be taken every clock cycle: a start loads a signed relative step count,
// a tick advances the move by one microsecond. Each transaction yields exactly one result,
// presented on the result port through the input register and then the result register.
// One more transaction is taken while a result waits on a stalled output, then the input
// stalls. The interval is computed in one pass: the ramp product slope*distance is kept in a
// running accumulator that moves by at most one slope per step, and the divide by 50000 is a
// single multiply by a reciprocal followed by the limit clamps. There are no memories and no
// clearing pass after reset. Configuration is to be written by the user through the APB-style
// port only while idle; the block itself does not enforce this.
module stepper_ramp_move_generator #(
   parameter int COUNT_WIDTH    = 24,
   parameter int INTERVAL_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  srmg_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output srmg_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [srmg_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [srmg_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [srmg_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int PROD_W = COUNT_WIDTH + srmg_pkg::SLOPE_W;
   localparam logic [32:0] CNT_MAX = 33'((64'd1 << COUNT_WIDTH) - 64'd1);

   srmg_pkg::cfg_type cfg_ff, cfg_in;

   logic              in_valid_ff, in_valid_in;
   srmg_pkg::req_type in_data_ff;
   logic              proc_fire;

   logic              rsp_valid_ff, rsp_valid_in;
   srmg_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [COUNT_WIDTH-1:0]    steps_done_ff, steps_done_in;
   logic [COUNT_WIDTH-1:0]    steps_target_ff, steps_target_in;
   logic                      direction_ccw_ff, direction_ccw_in;
   logic [INTERVAL_WIDTH-1:0] interval_left_ff, interval_left_in;
   logic [31:0]               elapsed_us_ff, elapsed_us_in;
   logic                      moving_ff, moving_in;
   logic [PROD_W-1:0]         ramp_prod_ff, ramp_prod_in;

   logic [INTERVAL_WIDTH-1:0] next_ivl;
   logic [COUNT_WIDTH-1:0]    steps_left;
   logic [COUNT_WIDTH-1:0]    dist_cur;
   logic [COUNT_WIDTH-1:0]    done_p1;
   logic [COUNT_WIDTH-1:0]    left_m1;
   logic [COUNT_WIDTH-1:0]    dist_nxt;
   logic [31:0]               elapsed_inc;
   logic [srmg_pkg::MOVE_W-1:0] raw_ticks;
   logic                      raw_neg;
   logic [srmg_pkg::MOVE_W:0] mag;
   logic [32:0]               mag_ext;
   logic                      csr_write;

   // configuration writes
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[4:2])
            srmg_pkg::REG_RAMP_SLOPE:      cfg_in.ramp_slope      = csr_pwdata[11:0];
            srmg_pkg::REG_RAMP_INTERCEPT:  cfg_in.ramp_intercept  = csr_pwdata[23:0];
            srmg_pkg::REG_INTERVAL_MIN:    cfg_in.interval_min    = csr_pwdata[15:0];
            srmg_pkg::REG_INTERVAL_MAX:    cfg_in.interval_max    = csr_pwdata[15:0];
            srmg_pkg::REG_MOVE_TIMEOUT_US: cfg_in.move_timeout_us = csr_pwdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_paddr[4:2])
         srmg_pkg::REG_RAMP_SLOPE:      csr_prdata = 32'(cfg_ff.ramp_slope);
         srmg_pkg::REG_RAMP_INTERCEPT:  csr_prdata = 32'(cfg_ff.ramp_intercept);
         srmg_pkg::REG_INTERVAL_MIN:    csr_prdata = 32'(cfg_ff.interval_min);
         srmg_pkg::REG_INTERVAL_MAX:    csr_prdata = 32'(cfg_ff.interval_max);
         srmg_pkg::REG_MOVE_TIMEOUT_US: csr_prdata = cfg_ff.move_timeout_us;
         default:                       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_slope      <= srmg_pkg::RAMP_SLOPE_RST;
         cfg_ff.ramp_intercept  <= srmg_pkg::RAMP_INTERCEPT_RST;
         cfg_ff.interval_min    <= srmg_pkg::INTERVAL_MIN_RST;
         cfg_ff.interval_max    <= srmg_pkg::INTERVAL_MAX_RST;
         cfg_ff.move_timeout_us <= srmg_pkg::MOVE_TIMEOUT_US_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake: input register feeds the processing pass, result register holds output
   assign proc_fire   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !proc_fire;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !proc_fire);

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // interval for the current distance
   srmg_interval #(
      .COUNT_WIDTH    (COUNT_WIDTH),
      .INTERVAL_WIDTH (INTERVAL_WIDTH)
   ) u_interval (
      .ramp_prod (ramp_prod_ff),
      .cfg       (cfg_ff),
      .interval  (next_ivl)
   );

   // distance to the nearer end of the move, now and after one more step
   assign steps_left  = steps_target_ff - steps_done_ff;
   assign dist_cur    = (steps_done_ff < steps_left) ? steps_done_ff : steps_left;
   assign done_p1     = steps_done_ff + COUNT_WIDTH'(1);
   assign left_m1     = steps_left - COUNT_WIDTH'(1);
   assign dist_nxt    = (done_p1 < left_m1) ? done_p1 : left_m1;
   assign elapsed_inc = (elapsed_us_ff == '1) ? elapsed_us_ff : elapsed_us_ff + 32'd1;

   // start transaction: magnitude with saturation to the count range
   assign raw_ticks = in_data_ff.move_ticks;
   assign raw_neg   = raw_ticks[srmg_pkg::MOVE_W-1];
   assign mag       = raw_neg ? ((srmg_pkg::MOVE_W+1)'(1) << srmg_pkg::MOVE_W)
                                - {1'b0, raw_ticks}
                              : {1'b0, raw_ticks};
   assign mag_ext   = 33'(mag);

   // move state update and result
   always_comb begin
      steps_done_in    = steps_done_ff;
      steps_target_in  = steps_target_ff;
      direction_ccw_in = direction_ccw_ff;
      interval_left_in = interval_left_ff;
      elapsed_us_in    = elapsed_us_ff;
      moving_in        = moving_ff;
      ramp_prod_in     = ramp_prod_ff;
      rsp_data_in      = '0;
      if (proc_fire) begin
         if (in_data_ff.action == srmg_pkg::ACTION_START) begin
            steps_done_in    = '0;
            steps_target_in  = (mag_ext > CNT_MAX) ? CNT_MAX[COUNT_WIDTH-1:0]
                                                   : mag_ext[COUNT_WIDTH-1:0];
            direction_ccw_in = !raw_neg && (raw_ticks != '0);
            interval_left_in = INTERVAL_WIDTH'(1);
            elapsed_us_in    = '0;
            moving_in        = 1'b1;
            ramp_prod_in     = '0;
         end else if (moving_ff) begin
            elapsed_us_in = elapsed_inc;
            if (interval_left_ff <= INTERVAL_WIDTH'(1)) begin
               if (steps_done_ff >= steps_target_ff) begin
                  rsp_data_in.move_done = 1'b1;
                  moving_in             = 1'b0;
                  interval_left_in      = '0;
               end else begin
                  rsp_data_in.step_pulse = 1'b1;
                  steps_done_in          = done_p1;
                  interval_left_in       = next_ivl;
                  if (dist_nxt > dist_cur) begin
                     ramp_prod_in = ramp_prod_ff + PROD_W'(cfg_ff.ramp_slope);
                  end else if (dist_nxt < dist_cur) begin
                     ramp_prod_in = ramp_prod_ff - PROD_W'(cfg_ff.ramp_slope);
                  end
               end
            end else begin
               interval_left_in = interval_left_ff - INTERVAL_WIDTH'(1);
            end
            // timeout after the event of this tick
            if (moving_in && (elapsed_inc >= cfg_ff.move_timeout_us)) begin
               rsp_data_in.move_timed_out = 1'b1;
               moving_in                  = 1'b0;
               interval_left_in           = '0;
            end
         end
         rsp_data_in.step_ccw = direction_ccw_in;
         rsp_data_in.busy_res = moving_in;
      end
   end

   assign rsp_valid_in = proc_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         steps_done_ff    <= '0;
         steps_target_ff  <= '0;
         direction_ccw_ff <= 1'b0;
         interval_left_ff <= '0;
         elapsed_us_ff    <= '0;
         moving_ff        <= 1'b0;
         ramp_prod_ff     <= '0;
      end else begin
         in_valid_ff      <= in_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         steps_done_ff    <= steps_done_in;
         steps_target_ff  <= steps_target_in;
         direction_ccw_ff <= direction_ccw_in;
         interval_left_ff <= interval_left_in;
         elapsed_us_ff    <= elapsed_us_in;
         moving_ff        <= moving_in;
         ramp_prod_ff     <= ramp_prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // a processed start always leaves a move running
   a_start_moves: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && (in_data_ff.action == srmg_pkg::ACTION_START)) |=> moving_ff)
      else $error("start transaction did not begin a move");

   // progress never passes the target
   a_done_le_target: assert property (@(posedge clock) disable iff (reset)
      steps_done_ff <= steps_target_ff)
      else $error("steps done exceeds target");

   // a running move always has a pending event
   a_interval_live: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (interval_left_ff != '0))
      else $error("running move with no interval left");

   // a tick while idle keeps the block idle
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && (in_data_ff.action == srmg_pkg::ACTION_TICK) && !moving_ff)
      |=> !moving_ff)
      else $error("idle tick started a move");
`endif

endmodule

// File: tb/stepper_ramp_move_generator_tb.sv
// self-checking testbench for the stepper ramp move generator

// tracks the move state and queues the result each accepted transaction must give
class ramp_move_checker;
   logic [srmg_pkg::SLOPE_W-1:0]   slope;
   logic [srmg_pkg::ICEPT_W-1:0]   icept;
   logic [srmg_pkg::LIMIT_W-1:0]   ivl_min;
   logic [srmg_pkg::LIMIT_W-1:0]   ivl_max;
   logic [srmg_pkg::TIMEOUT_W-1:0] tmo_us;

   logic [srmg_pkg::MOVE_W-1:0]    steps_done;
   logic [srmg_pkg::MOVE_W-1:0]    steps_target;
   logic                           dir_ccw;
   logic [srmg_pkg::LIMIT_W-1:0]   ivl_left;
   logic [31:0]                    elapsed;
   logic                           moving;

   srmg_pkg::rsp_type              pending_results[$];
   int                             errors;
   int                             results_seen;

   function new();
      slope        = srmg_pkg::RAMP_SLOPE_RST;
      icept        = srmg_pkg::RAMP_INTERCEPT_RST;
      ivl_min      = srmg_pkg::INTERVAL_MIN_RST;
      ivl_max      = srmg_pkg::INTERVAL_MAX_RST;
      tmo_us       = srmg_pkg::MOVE_TIMEOUT_US_RST;
      steps_done   = '0;
      steps_target = '0;
      dir_ccw      = 1'b0;
      ivl_left     = '0;
      elapsed      = '0;
      moving       = 1'b0;
      errors       = 0;
      results_seen = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
         srmg_pkg::REG_RAMP_SLOPE:      slope   = value[srmg_pkg::SLOPE_W-1:0];
         srmg_pkg::REG_RAMP_INTERCEPT:  icept   = value[srmg_pkg::ICEPT_W-1:0];
         srmg_pkg::REG_INTERVAL_MIN:    ivl_min = value[srmg_pkg::LIMIT_W-1:0];
         srmg_pkg::REG_INTERVAL_MAX:    ivl_max = value[srmg_pkg::LIMIT_W-1:0];
         srmg_pkg::REG_MOVE_TIMEOUT_US: tmo_us  = value[srmg_pkg::TIMEOUT_W-1:0];
         default: ;
      endcase
   endfunction

   // ramp interval for the current distance, after quantizing and clamping
   function logic [srmg_pkg::LIMIT_W-1:0] ramp_interval();
      longint left;
      longint span;
      longint v;
      longint q;
      left = longint'(steps_target) - longint'(steps_done);
      span = (longint'(steps_done) < left) ? longint'(steps_done) : left;
      v    = longint'(icept) - longint'(slope) * span;
      q    = v / 1000;
      q    = (q / 50) * 50;
      if (q < longint'(ivl_min))
         q = longint'(ivl_min);
      if (q > longint'(ivl_max))
         q = longint'(ivl_max);
      if (q < 1)
         q = 1;
      if (q > 65535)
         q = 65535;
      return q[srmg_pkg::LIMIT_W-1:0];
   endfunction

   // advance the move by one accepted transaction and queue its result
   function void note_command(srmg_pkg::req_type cmd);
      srmg_pkg::rsp_type            res;
      logic [srmg_pkg::MOVE_W-1:0]  raw;
      logic [srmg_pkg::MOVE_W:0]    mag;
      logic                         neg;
      logic [srmg_pkg::LIMIT_W-1:0] ivl;
      res = '0;
      if (cmd.action == srmg_pkg::ACTION_START) begin
         raw = cmd.move_ticks;
         neg = raw[srmg_pkg::MOVE_W-1];
         mag = neg ? ((srmg_pkg::MOVE_W+1)'(1) << srmg_pkg::MOVE_W) - {1'b0, raw}
                   : {1'b0, raw};
         if (mag > {1'b0, {srmg_pkg::MOVE_W{1'b1}}})
            mag = {1'b0, {srmg_pkg::MOVE_W{1'b1}}};
         steps_done   = '0;
         steps_target = mag[srmg_pkg::MOVE_W-1:0];
         dir_ccw      = !neg && raw != '0;
         ivl_left     = 1;
         elapsed      = '0;
         moving       = 1'b1;
      end else if (moving) begin
         if (elapsed != 32'hFFFF_FFFF)
            elapsed++;
         if (ivl_left <= 1) begin
            ivl = ramp_interval();
            if (steps_done >= steps_target) begin
               res.move_done = 1'b1;
               moving        = 1'b0;
               ivl_left      = '0;
            end else begin
               res.step_pulse = 1'b1;
               steps_done     = steps_done + 1'b1;
               ivl_left       = ivl;
            end
         end else begin
            ivl_left--;
         end
         // event is handled before the timeout is looked at
         if (moving && elapsed >= tmo_us) begin
            res.move_timed_out = 1'b1;
            moving             = 1'b0;
            ivl_left           = '0;
         end
      end
      res.step_ccw = dir_ccw;
      res.busy_res = moving;
      pending_results.push_back(res);
   endfunction

   task report_mismatch(string msg);
      errors++;
      if (errors <= 20)
         $display("mismatch at result %0d: %s", results_seen, msg);
   endtask

   task check_result(srmg_pkg::rsp_type got);
      srmg_pkg::rsp_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("result with no transaction outstanding");
      end else begin
         want = pending_results.pop_front();
         if (got.step_pulse !== want.step_pulse)
            report_mismatch($sformatf("step_pulse %b, want %b", got.step_pulse, want.step_pulse));
         if (got.step_ccw !== want.step_ccw)
            report_mismatch($sformatf("step_ccw %b, want %b", got.step_ccw, want.step_ccw));
         if (got.move_done !== want.move_done)
            report_mismatch($sformatf("move_done %b, want %b", got.move_done, want.move_done));
         if (got.move_timed_out !== want.move_timed_out)
            report_mismatch($sformatf("move_timed_out %b, want %b",
                                      got.move_timed_out, want.move_timed_out));
         if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
      end
      results_seen++;
   endtask
endclass

module stepper_ramp_move_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD      = 8;
   localparam int RESET_CYCLES    = 11;
   localparam int ITEM_TARGET     = 1850;
   localparam int PHASE_ITEMS     = 150;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 4;
   localparam int CYCLE_LIMIT     = 1000000;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   srmg_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   srmg_pkg::rsp_type               rsp_data;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [srmg_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [srmg_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [srmg_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   ramp_move_checker tracker;
   int               items_sent   = 0;
   int               snd_idle_pct = 0;
   int               rcv_idle_pct = 0;
   bit               hold_off_req = 1'b0;
   int               cycles       = 0;

   stepper_ramp_move_generator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(rsp_data);
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(int pct);
      if ($urandom_range(0, 99) >= pct)
         return 0;
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // result side stall pattern, with the occasional long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap(rcv_idle_pct);
         end
      end
   end

   // offer one transaction and hold it until it is taken
   task automatic send_command(input logic act,
                               input logic signed [srmg_pkg::MOVE_W-1:0] ticks);
      srmg_pkg::req_type cmd;
      int                gap;
      cmd.action     = act;
      cmd.move_ticks = ticks;
      items_sent++;
      gap = pick_gap(snd_idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (req_stall);
      tracker.note_command(cmd);
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_command(srmg_pkg::ACTION_TICK, (srmg_pkg::MOVE_W)'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (tracker.pending_results.size() != 0)
         @(negedge clock);
   endtask

   // leave the block idle with no move running
   task automatic settle();
      send_command(srmg_pkg::ACTION_START, '0);
      send_tick();
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // register write, only with nothing in flight
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      tracker.write_reg(idx, value);
   endtask

   task automatic apply_cfg(input logic [31:0] slope, input logic [31:0] icept,
                            input logic [31:0] lo, input logic [31:0] hi,
                            input logic [31:0] tmo);
      csr_write(srmg_pkg::REG_RAMP_SLOPE, slope);
      csr_write(srmg_pkg::REG_RAMP_INTERCEPT, icept);
      csr_write(srmg_pkg::REG_INTERVAL_MIN, lo);
      csr_write(srmg_pkg::REG_INTERVAL_MAX, hi);
      csr_write(srmg_pkg::REG_MOVE_TIMEOUT_US, tmo);
   endtask

   // step count for a start: mostly short moves, some extremes and full-range values
   function automatic logic signed [srmg_pkg::MOVE_W-1:0] random_move();
      int pick;
      int m;
      pick = $urandom_range(0, 9);
      m    = $urandom_range(0, 40);
      if (pick == 0)
         return (srmg_pkg::MOVE_W)'($urandom);
      if (pick == 1) begin
         case ($urandom_range(0, 3))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return '0;
            default: return -24'sd1;
         endcase
      end
      return ($urandom_range(0, 1) != 0) ? -(srmg_pkg::MOVE_W)'(m)
                                         : (srmg_pkg::MOVE_W)'(m);
   endfunction

   // moves with random content, restarts while busy and idle ticks as noise
   task automatic run_random(input int n);
      int first;
      bit held;
      bit paused;
      first  = items_sent;
      held   = 1'b0;
      paused = 1'b0;
      while (items_sent - first < n) begin
         if (!held && items_sent - first >= n / 3) begin
            hold_off_req = 1'b1;
            held         = 1'b1;
         end
         if (!paused && items_sent - first >= 2 * n / 3) begin
            wait_drained();
            paused = 1'b1;
         end
         if (!tracker.moving && $urandom_range(0, 4) == 0)
            send_tick();
         else if (!tracker.moving || $urandom_range(0, 99) < 2)
            send_command(srmg_pkg::ACTION_START, random_move());
         else
            send_tick();
      end
   endtask

   initial begin
      logic [31:0] c_slope;
      logic [31:0] c_icept;
      logic [31:0] c_min;
      logic [31:0] c_max;
      logic [31:0] c_tmo;
      tracker     = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // register values out of reset
      send_command(srmg_pkg::ACTION_START, 24'sd3);
      send_tick();
      settle();

      // two-tick interval, timeout on the fifth tick
      apply_cfg(0, 2000, 2, 3, 5);
      // move ends done on the timeout tick, so no timeout
      send_command(srmg_pkg::ACTION_START, 24'sd2);
      repeat (5) send_tick();
      // step issued on the timeout tick, reported with the flag
      send_command(srmg_pkg::ACTION_START, 24'sh7FFFFF);
      repeat (5) send_tick();
      // most negative count, then restart while busy with zero steps
      send_command(srmg_pkg::ACTION_START, 24'sh800000);
      send_tick();
      send_command(srmg_pkg::ACTION_START, '0);
      send_tick();
      settle();

      // zero timeout and an interval that falls below one
      apply_cfg(0, 0, 0, 0, 0);
      send_command(srmg_pkg::ACTION_START, 24'sd5);
      send_tick();
      send_command(srmg_pkg::ACTION_START, '0);
      send_tick();
      csr_write(srmg_pkg::REG_MOVE_TIMEOUT_US, 10);
      send_command(srmg_pkg::ACTION_START, -24'sd3);
      repeat (4) send_tick();
      settle();

      // upper extremes of every register
      snd_idle_pct = 20;
      rcv_idle_pct = 20;
      apply_cfg(32'hFFF, 32'hFF_FFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF);
      run_random(40);
      settle();

      // random register settings, each for one phase
      while (items_sent < ITEM_TARGET) begin
         c_slope = $urandom_range(0, 4095);
         case ($urandom_range(0, 4))
            0: begin
               // minimum above maximum
               c_icept = $urandom_range(0, 500000);
               c_min   = $urandom_range(10, 120);
               c_max   = $urandom_range(1, c_min - 1);
            end
            1: begin
               // full-range intercept against a short maximum
               c_icept = $urandom_range(0, 24'hFF_FFFF);
               c_min   = $urandom_range(1, 20);
               c_max   = $urandom_range(c_min, 150);
            end
            default: begin
               c_icept = $urandom_range(0, 250000);
               c_min   = $urandom_range(1, 3);
               c_max   = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8)
                                                     : $urandom_range(50, 300);
            end
         endcase
         case ($urandom_range(0, 3))
            0:       c_tmo = $urandom_range(1, 40);
            1:       c_tmo = $urandom_range(41, 600);
            2:       c_tmo = $urandom;
            default: c_tmo = 32'hFFFF_FFFF;
         endcase
         case ($urandom_range(0, 2))
            0:       snd_idle_pct = 0;
            1:       snd_idle_pct = 20;
            default: snd_idle_pct = 50;
         endcase
         case ($urandom_range(0, 2))
            0:       rcv_idle_pct = 0;
            1:       rcv_idle_pct = 20;
            default: rcv_idle_pct = 50;
         endcase
         apply_cfg(c_slope, c_icept, c_min, c_max, c_tmo);
         run_random(PHASE_ITEMS);
         settle();
      end

      wait_drained();
      repeat (2 * DRAIN_CYCLES) @(negedge clock);
      if (tracker.errors == 0 && tracker.pending_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
